### hw/rtl/plic_pkg.sv
package plic_pkg;

  // Sizing of the controller
  localparam int unsigned NUM_SOURCES   = 32;
  localparam int unsigned NUM_CONTEXTS  = 2;
  localparam int unsigned PRIORITY_BITS = 3;

  localparam int unsigned SRC_W     = $clog2(NUM_SOURCES);
  localparam int unsigned SRC_PAD   = 1 << SRC_W;
  localparam int unsigned CTX_W     = (NUM_CONTEXTS > 1) ? $clog2(NUM_CONTEXTS) : 1;
  localparam int unsigned CTX_PAD   = (NUM_CONTEXTS > 2) ? NUM_CONTEXTS : 2;
  localparam int unsigned NUM_WORDS = (NUM_SOURCES + 31) / 32;
  localparam int unsigned LINES     = (NUM_SOURCES < 32) ? NUM_SOURCES : 32;

  // Field widths of one transfer
  localparam int unsigned CMD_W  = 2;
  localparam int unsigned OFF_W  = 26;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned LVL_W  = 32;
  localparam int unsigned REQ_W  = 2;
  localparam int unsigned IN_W   = 96;
  localparam int unsigned OUT_W  = 40;

  // Register window
  localparam logic [OFF_W-1:0] OFF_PENDING   = OFF_W'(32'h1000);
  localparam logic [OFF_W-1:0] OFF_ENABLE    = OFF_W'(32'h2000);
  localparam logic [OFF_W-1:0] OFF_THRESHOLD = OFF_W'(32'h200000);
  localparam int unsigned      ENABLE_STRIDE = 32'h80;
  localparam int unsigned      CTX_STRIDE    = 32'h1000;
  localparam int unsigned      EN_CTX_LSB    = $clog2(ENABLE_STRIDE);
  localparam int unsigned      TH_CTX_LSB    = $clog2(CTX_STRIDE);
  localparam logic [TH_CTX_LSB-1:0] REG_THRESHOLD = '0;
  localparam logic [TH_CTX_LSB-1:0] REG_CLAIM     = TH_CTX_LSB'(4);

  // Sources that exist and can be pending (source zero never)
  localparam logic [NUM_SOURCES-1:0] VALID_MASK = {{(NUM_SOURCES-1){1'b1}}, 1'b0};

  typedef enum logic [CMD_W-1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_IDLE  = 2'd2
  } cmd_e;

endpackage

### hw/rtl/platform_interrupt_controller.sv
// Platform-level interrupt controller with a 32-bit register window. Each input
// transfer carries one bus access (read, write or idle tick) and a sample of the
// level-triggered source lines; each produces exactly one output transfer with
// the read word and the per-context request bits formed after the access. One
// transfer is taken every clock cycle unless the output stalls; each result passes
// through the input register and then the result register. The compute stage holds
// the priority arbitration tree over all sources, which sets the clock.
module platform_interrupt_controller (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // [1:0] cmd, [27:2] reg_offset, [59:28] write_data, [91:60] source_levels
  input  logic [plic_pkg::IN_W-1:0]       s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [31:0] read_data, [33:32] context_requests
  output logic [plic_pkg::OUT_W-1:0]      m_axis_tdata
);

  localparam int unsigned NS  = plic_pkg::NUM_SOURCES;
  localparam int unsigned NC  = plic_pkg::NUM_CONTEXTS;
  localparam int unsigned PW  = plic_pkg::PRIORITY_BITS;
  localparam int unsigned SW  = plic_pkg::SRC_W;
  localparam int unsigned CW  = plic_pkg::CTX_W;
  localparam int unsigned OW  = plic_pkg::OFF_W;
  localparam int unsigned DW  = plic_pkg::DATA_W;
  localparam int unsigned LVS = $clog2(plic_pkg::SRC_PAD);

  // Input stage
  logic                        in_valid_q;
  logic [plic_pkg::CMD_W-1:0]  cmd_q;
  logic [OW-1:0]               off_q;
  logic [DW-1:0]               wdata_q;
  logic [plic_pkg::LVL_W-1:0]  levels_q;

  // Result stage
  logic                        out_valid_q;
  logic [DW-1:0]               rdata_q, rdata_d;
  logic [plic_pkg::REQ_W-1:0]  req_q, req_d;

  // Controller state
  logic [PW-1:0] prio_q [NS];
  logic [PW-1:0] prio_d [NS];
  logic [NS-1:0] pend_q, pend_d;
  logic [NS-1:0] infl_q, infl_d;
  logic [NS-1:0] en_q [NC];
  logic [NS-1:0] en_d [NC];
  logic [PW-1:0] thr_q [NC];
  logic [PW-1:0] thr_d [NC];

  logic advance;

  // Decode and datapath signals
  logic          is_rd, is_wr;
  logic [OW-1:0] off;
  logic [NS-1:0] lines;
  logic [NS-1:0] pend_gw;
  logic [63:0]   pend_pad, en_pad;
  logic [9:0]    word_idx;
  logic [OW-1:0] rel_en, rel_th;
  logic [OW-1:0] en_ctx_f, th_ctx_f;
  logic [4:0]    en_w;
  logic [plic_pkg::TH_CTX_LSB-1:0] th_r;
  logic          en_ctx_ok, th_ctx_ok;
  logic [CW-1:0] en_ctx, th_ctx;
  logic [NS-1:0] en_new;
  logic [NS-1:0] cand;
  logic [PW-1:0] node_p [LVS+1][plic_pkg::SRC_PAD];
  logic [SW-1:0] node_id [LVS+1][plic_pkg::SRC_PAD];
  logic [SW-1:0] claim_id;
  logic          claim_hit;
  logic [SW-1:0] cpl_id;
  logic [plic_pkg::CTX_PAD-1:0] req_all;
  logic [NS-1:0] cand_d;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(plic_pkg::OUT_W - DW - plic_pkg::REQ_W){1'b0}}, req_q, rdata_q};

  // Hold the accepted transfer for the compute stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      cmd_q    <= s_axis_tdata[1:0];
      off_q    <= s_axis_tdata[27:2];
      wdata_q  <= s_axis_tdata[59:28];
      levels_q <= s_axis_tdata[91:60];
    end
  end

  // Address decode of the word offset
  always_comb begin
    is_rd     = (plic_pkg::cmd_e'(cmd_q) == plic_pkg::CMD_READ);
    is_wr     = (plic_pkg::cmd_e'(cmd_q) == plic_pkg::CMD_WRITE);
    off       = {off_q[OW-1:2], 2'b00};
    word_idx  = off[11:2];
    rel_en    = off - plic_pkg::OFF_ENABLE;
    rel_th    = off - plic_pkg::OFF_THRESHOLD;
    en_ctx_f  = rel_en >> plic_pkg::EN_CTX_LSB;
    th_ctx_f  = rel_th >> plic_pkg::TH_CTX_LSB;
    en_w      = rel_en[plic_pkg::EN_CTX_LSB-1:2];
    th_r      = rel_th[plic_pkg::TH_CTX_LSB-1:0];
    en_ctx_ok = (en_ctx_f < OW'(NC));
    th_ctx_ok = (th_ctx_f < OW'(NC));
    en_ctx    = en_ctx_ok ? en_ctx_f[CW-1:0] : '0;
    th_ctx    = th_ctx_ok ? th_ctx_f[CW-1:0] : '0;
  end

  // Gateways: raise pending for high lines not already pending or in flight
  always_comb begin
    lines = '0;
    for (int i = 0; i < plic_pkg::LINES; i++) begin
      lines[i] = levels_q[i];
    end
    pend_gw  = pend_q | (lines & plic_pkg::VALID_MASK & ~infl_q);
    pend_pad = '0;
    en_pad   = '0;
    for (int i = 0; i < NS; i++) begin
      pend_pad[i] = pend_gw[i];
      en_pad[i]   = en_q[en_ctx][i];
    end
  end

  // Claim arbitration tree for the addressed context; lower ID wins ties
  always_comb begin
    cand = pend_gw & en_q[th_ctx] & plic_pkg::VALID_MASK;
    for (int i = 0; i < plic_pkg::SRC_PAD; i++) begin
      node_id[0][i] = SW'(i);
      node_p[0][i]  = '0;
      if (i < NS) begin
        if (cand[i]) begin
          node_p[0][i] = prio_q[i];
        end
      end
    end
    for (int l = 0; l < LVS; l++) begin
      for (int n = 0; n < plic_pkg::SRC_PAD; n++) begin
        node_p[l+1][n]  = '0;
        node_id[l+1][n] = '0;
        if (n < (plic_pkg::SRC_PAD >> (l + 1))) begin
          if (node_p[l][2*n+1] > node_p[l][2*n]) begin
            node_p[l+1][n]  = node_p[l][2*n+1];
            node_id[l+1][n] = node_id[l][2*n+1];
          end else begin
            node_p[l+1][n]  = node_p[l][2*n];
            node_id[l+1][n] = node_id[l][2*n];
          end
        end
      end
    end
    claim_hit = (node_p[LVS][0] > thr_q[th_ctx]);
    claim_id  = claim_hit ? node_id[LVS][0] : '0;
  end

  // Perform the access and form the next state
  always_comb begin
    prio_d  = prio_q;
    en_d    = en_q;
    thr_d   = thr_q;
    pend_d  = pend_gw;
    infl_d  = infl_q;
    rdata_d = '0;
    cpl_id  = wdata_q[SW-1:0];
    en_new  = en_q[en_ctx];
    for (int i = 0; i < NS; i++) begin
      if ((i / 32) == int'(en_w[0])) begin
        en_new[i] = wdata_q[i % 32];
      end
    end

    if (is_rd || is_wr) begin
      if (off < plic_pkg::OFF_PENDING) begin
        if (word_idx < 10'(NS) && word_idx != '0) begin
          if (is_wr) begin
            prio_d[word_idx[SW-1:0]] = wdata_q[PW-1:0];
          end else begin
            rdata_d = DW'(prio_q[word_idx[SW-1:0]]);
          end
        end
      end else if (off < plic_pkg::OFF_ENABLE) begin
        if (word_idx < 10'(plic_pkg::NUM_WORDS) && is_rd) begin
          rdata_d = word_idx[0] ? pend_pad[63:32] : pend_pad[31:0];
        end
      end else if (off < plic_pkg::OFF_THRESHOLD) begin
        if (en_ctx_ok && en_w < 5'(plic_pkg::NUM_WORDS)) begin
          if (is_wr) begin
            en_d[en_ctx] = en_new & plic_pkg::VALID_MASK;
          end else begin
            rdata_d = en_w[0] ? en_pad[63:32] : en_pad[31:0];
          end
        end
      end else if (th_ctx_ok) begin
        if (th_r == plic_pkg::REG_THRESHOLD) begin
          if (is_wr) begin
            thr_d[th_ctx] = wdata_q[PW-1:0];
          end else begin
            rdata_d = DW'(thr_q[th_ctx]);
          end
        end else if (th_r == plic_pkg::REG_CLAIM) begin
          if (is_wr) begin
            // Release only an in-flight source enabled for this context
            if (wdata_q != '0 && wdata_q < DW'(NS)) begin
              if (infl_q[cpl_id] && en_q[th_ctx][cpl_id]) begin
                infl_d[cpl_id] = 1'b0;
              end
            end
          end else begin
            if (claim_hit) begin
              pend_d[claim_id] = 1'b0;
              infl_d[claim_id] = 1'b1;
            end
            rdata_d = DW'(claim_id);
          end
        end
      end
    end
  end

  // Request lines from the state after the access
  always_comb begin
    req_all = '0;
    for (int c = 0; c < NC; c++) begin
      cand_d = pend_d & en_d[c] & plic_pkg::VALID_MASK;
      for (int i = 0; i < NS; i++) begin
        if (cand_d[i] && (prio_d[i] > thr_d[c])) begin
          req_all[c] = 1'b1;
        end
      end
    end
    req_d = req_all[plic_pkg::REQ_W-1:0];
  end

  // Advance state and the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      pend_q      <= '0;
      infl_q      <= '0;
      for (int i = 0; i < NS; i++) begin
        prio_q[i] <= '0;
      end
      for (int c = 0; c < NC; c++) begin
        en_q[c]  <= '0;
        thr_q[c] <= '0;
      end
    end else begin
      if (advance) begin
        out_valid_q <= 1'b1;
        pend_q      <= pend_d;
        infl_q      <= infl_d;
        prio_q      <= prio_d;
        en_q        <= en_d;
        thr_q       <= thr_d;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      rdata_q <= rdata_d;
      req_q   <= req_d;
    end
  end

endmodule

### test/platform_interrupt_controller_tb.sv
module platform_interrupt_controller_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import plic_pkg::*;

  // Command code outside the package enum; the block treats it as an idle tick
  localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;
  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned RANDOM_ITEMS = 1400;
  localparam int unsigned HOLD_CYCLES = 120;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic [REQ_W-1:0]  requests;
  } response_t;

  // Shadow copy of the controller state and the queue of responses it predicts
  class plic_shadow;
    logic [PRIORITY_BITS-1:0] prio [NUM_SOURCES];
    logic [NUM_SOURCES-1:0]   pending;
    logic [NUM_SOURCES-1:0]   in_flight;
    logic [NUM_SOURCES-1:0]   enable [NUM_CONTEXTS];
    logic [PRIORITY_BITS-1:0] threshold [NUM_CONTEXTS];
    response_t                expected_q[$];
    int                       errors;

    function new();
      foreach (prio[i]) prio[i] = '0;
      foreach (enable[c]) begin
        enable[c] = '0;
        threshold[c] = '0;
      end
      pending = '0;
      in_flight = '0;
      errors = 0;
    endfunction

    // Highest priority enabled pending source above the threshold, lowest ID on ties
    function int unsigned best_claim(int unsigned c);
      int unsigned id;
      int unsigned top;
      id = 0;
      top = 32'(threshold[c]);
      for (int unsigned i = 1; i < NUM_SOURCES; i++) begin
        if (pending[i] && enable[c][i] && VALID_MASK[i] && 32'(prio[i]) > top) begin
          id = i;
          top = 32'(prio[i]);
        end
      end
      return id;
    endfunction

    // Apply one accepted transfer and queue the response it must produce
    function void take_access(logic [IN_W-1:0] word);
      logic [CMD_W-1:0]  cmd;
      logic [OFF_W-1:0]  off;
      logic [DATA_W-1:0] data;
      logic [LVL_W-1:0]  levels;
      logic [DATA_W-1:0] rd;
      int unsigned       rel, ctx, w, r, id;
      bit                rw, wr;
      response_t         resp;
      cmd = word[1:0];
      off = word[27:2] & ~OFF_W'(3);
      data = word[59:28];
      levels = word[91:60];
      rw = (cmd == CMD_READ) || (cmd == CMD_WRITE);
      wr = (cmd == CMD_WRITE);
      rd = '0;

      // Gateways first: high lines raise pending unless already in flight
      pending |= levels[NUM_SOURCES-1:0] & VALID_MASK & ~in_flight;

      if (rw) begin
        if (off < OFF_PENDING) begin
          id = 32'(off) / 4;
          if (id < NUM_SOURCES && id != 0) begin
            if (wr) prio[id] = data[PRIORITY_BITS-1:0];
            else rd = DATA_W'(prio[id]);
          end
        end else if (off < OFF_ENABLE) begin
          w = 32'(off - OFF_PENDING) / 4;
          if (w < NUM_WORDS && !wr) rd = pending;
        end else if (off < OFF_THRESHOLD) begin
          rel = 32'(off - OFF_ENABLE);
          ctx = rel / ENABLE_STRIDE;
          w = (rel % ENABLE_STRIDE) / 4;
          if (ctx < NUM_CONTEXTS && w < NUM_WORDS) begin
            if (wr) enable[ctx] = data[NUM_SOURCES-1:0] & VALID_MASK;
            else rd = enable[ctx];
          end
        end else begin
          rel = 32'(off - OFF_THRESHOLD);
          ctx = rel / CTX_STRIDE;
          r = rel % CTX_STRIDE;
          if (ctx < NUM_CONTEXTS) begin
            if (r == 32'(REG_THRESHOLD)) begin
              if (wr) threshold[ctx] = data[PRIORITY_BITS-1:0];
              else rd = DATA_W'(threshold[ctx]);
            end else if (r == 32'(REG_CLAIM)) begin
              if (wr) begin
                // Release only a source that is in flight and enabled here
                if (data > 0 && data < NUM_SOURCES) begin
                  id = data;
                  if (in_flight[id] && enable[ctx][id]) in_flight[id] = 1'b0;
                end
              end else begin
                id = best_claim(ctx);
                if (id != 0) begin
                  pending[id] = 1'b0;
                  in_flight[id] = 1'b1;
                end
                rd = id;
              end
            end
          end
        end
      end

      resp.read_data = wr ? '0 : rd;
      for (int unsigned c = 0; c < REQ_W; c++)
        resp.requests[c] = (c < NUM_CONTEXTS) && (best_claim(c) != 0);
      expected_q.push_back(resp);
    endfunction

    // Compare one delivered response with the oldest prediction
    function void match_response(logic [OUT_W-1:0] word);
      response_t exp_resp;
      if (expected_q.size() == 0) begin
        $error("response with nothing outstanding: %h", word);
        errors++;
        return;
      end
      exp_resp = expected_q.pop_front();
      if (word[31:0] !== exp_resp.read_data) begin
        $error("read_data: expected %h, actual %h", exp_resp.read_data, word[31:0]);
        errors++;
      end
      if (word[33:32] !== exp_resp.requests) begin
        $error("context_requests: expected %b, actual %b", exp_resp.requests, word[33:32]);
        errors++;
      end
    endfunction
  endclass

  logic             clk_i;
  logic             rst_ni;
  logic             s_axis_tvalid;
  logic             s_axis_tready;
  logic [IN_W-1:0]  s_axis_tdata;
  logic             m_axis_tvalid;
  logic             m_axis_tready;
  logic [OUT_W-1:0] m_axis_tdata;

  plic_shadow  shadow = new();
  bit          calm;
  bit          held;
  int unsigned issued;
  int unsigned quiet_cycles;

  platform_interrupt_controller dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // Offer one access and hold it until the transfer completes
  task automatic bus_access(input logic [CMD_W-1:0] cmd, input int unsigned off,
                            input logic [DATA_W-1:0] data, input logic [LVL_W-1:0] levels);
    if (!calm && $urandom_range(0, 99) < 6) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {4'b0, levels, data, OFF_W'(off), cmd};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    issued++;
    @(negedge clk_i);
  endtask

  // Track accepted inputs and check delivered responses
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) shadow.take_access(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) shadow.match_response(m_axis_tdata);
    end
  end

  // Watchdog: give up after a long run of cycles without any transfer
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Receiver: occasional stalls, one long hold-off to back the block up
  initial begin
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!held && issued >= 300) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        held = 1'b1;
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= calm || ($urandom_range(0, 99) >= 6);
      end
    end
  end

  // Sender: directed accesses, then random traffic, then drain and report
  initial begin
    logic [CMD_W-1:0]  cmd;
    int unsigned       off;
    logic [DATA_W-1:0] data;
    logic [LVL_W-1:0]  levels;
    int unsigned       pick, ctx, id;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    rst_ni = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Priorities: masking of wide values, source zero hardwired, low offset bits ignored
    bus_access(CMD_WRITE, 4 * 1, 32'hFFFF_FFFF, '0);
    bus_access(CMD_WRITE, 4 * 31, 32'd7, '0);
    bus_access(CMD_WRITE, 0, 32'd5, '0);
    bus_access(CMD_READ, 0, '0, '0);
    bus_access(CMD_READ, 4 * 1, '0, '0);
    bus_access(CMD_WRITE, 4 * 2 + 3, 32'd3, '0);
    // Enables: source zero dropped, second word absent
    bus_access(CMD_WRITE, 32'(OFF_ENABLE), 32'hFFFF_FFFF, '0);
    bus_access(CMD_WRITE, 32'(OFF_ENABLE) + ENABLE_STRIDE, 32'h8000_0004, '0);
    bus_access(CMD_READ, 32'(OFF_ENABLE), '0, '0);
    bus_access(CMD_WRITE, 32'(OFF_ENABLE) + 4, 32'hFFFF_FFFF, '0);
    // Thresholds
    bus_access(CMD_WRITE, 32'(OFF_THRESHOLD) + CTX_STRIDE, 32'hFFFF_FFFF, '0);
    bus_access(CMD_READ, 32'(OFF_THRESHOLD) + CTX_STRIDE, '0, '0);
    bus_access(CMD_WRITE, 32'(OFF_THRESHOLD) + CTX_STRIDE, 32'd1, '0);
    // Raise every line, read pending, try to overwrite it
    bus_access(CMD_IDLE, 0, '0, 32'hFFFF_FFFF);
    bus_access(CMD_READ, 32'(OFF_PENDING), '0, '0);
    bus_access(CMD_WRITE, 32'(OFF_PENDING), 32'h0000_FFFF, '0);
    // Claims: tie at top priority, then the other context
    bus_access(CMD_READ, 32'(OFF_THRESHOLD) + 32'(REG_CLAIM), '0, '0);
    bus_access(CMD_READ, 32'(OFF_THRESHOLD) + CTX_STRIDE + 32'(REG_CLAIM), '0, '0);
    // Foreign completions: not enabled, zero, out of range, not in flight; then a real one
    bus_access(CMD_WRITE, 32'(OFF_THRESHOLD) + CTX_STRIDE + 32'(REG_CLAIM), 32'd1, '0);
    bus_access(CMD_WRITE, 32'(OFF_THRESHOLD) + 32'(REG_CLAIM), 32'd0, '0);
    bus_access(CMD_WRITE, 32'(OFF_THRESHOLD) + 32'(REG_CLAIM), 32'd40, '0);
    bus_access(CMD_WRITE, 32'(OFF_THRESHOLD) + 32'(REG_CLAIM), 32'd5, '0);
    bus_access(CMD_WRITE, 32'(OFF_THRESHOLD) + 32'(REG_CLAIM), 32'd1, 32'h0000_0002);
    // Unmapped offsets and the spare command
    bus_access(CMD_READ, 32'h3FF_FFFF, '0, '0);
    bus_access(CMD_WRITE, 32'(OFF_THRESHOLD) + 8, 32'd3, '0);
    bus_access(CMD_READ, 32'(OFF_THRESHOLD) + 2 * CTX_STRIDE + 32'(REG_CLAIM), '0, '0);
    bus_access(CMD_SPARE, 32'(OFF_THRESHOLD) + 32'(REG_CLAIM), '0, 32'h5555_5554);
    // Claim with nothing above the threshold
    bus_access(CMD_WRITE, 32'(OFF_THRESHOLD), 32'd7, '0);
    bus_access(CMD_READ, 32'(OFF_THRESHOLD) + 32'(REG_CLAIM), '0, '0);
    bus_access(CMD_WRITE, 32'(OFF_THRESHOLD), 32'd0, '0);

    // Random traffic, mostly well-formed register accesses with claims and completions
    for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
      calm = (n >= 600 && n < 900);
      case ($urandom_range(0, 9))
        0: levels = '0;
        1: levels = '1;
        default: levels = $urandom & $urandom & $urandom;
      endcase
      cmd = $urandom_range(0, 1) ? CMD_WRITE : CMD_READ;
      data = $urandom;
      ctx = $urandom_range(0, 4) == 0 ? 2 : $urandom_range(0, 1);
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        cmd = CMD_W'($urandom_range(0, 3));
        off = $urandom;
      end else if (pick < 30) begin
        off = 4 * $urandom_range(0, NUM_SOURCES - 1) + $urandom_range(0, 3);
        if ($urandom_range(0, 3) != 0) data = $urandom_range(0, 7);
      end else if (pick < 38) begin
        off = 32'(OFF_PENDING) + 4 * $urandom_range(0, 1);
      end else if (pick < 50) begin
        off = 32'(OFF_ENABLE) + ENABLE_STRIDE * ctx + 4 * $urandom_range(0, 1);
      end else if (pick < 58) begin
        off = 32'(OFF_THRESHOLD) + CTX_STRIDE * ctx;
        if ($urandom_range(0, 4) != 0) data = $urandom_range(0, 3);
      end else if (pick < 78) begin
        cmd = CMD_READ;
        off = 32'(OFF_THRESHOLD) + CTX_STRIDE * ctx + 32'(REG_CLAIM);
      end else if (pick < 95) begin
        // Complete a source that is in flight most of the time
        cmd = CMD_WRITE;
        off = 32'(OFF_THRESHOLD) + CTX_STRIDE * ctx + 32'(REG_CLAIM);
        if (shadow.in_flight != '0 && $urandom_range(0, 3) != 0) begin
          do id = $urandom_range(1, NUM_SOURCES - 1); while (!shadow.in_flight[id]);
          data = id;
        end else if ($urandom_range(0, 3) != 0) begin
          data = $urandom_range(0, 40);
        end
      end else begin
        cmd = CMD_IDLE;
        off = $urandom;
      end
      bus_access(cmd, off, data, levels);
    end
    s_axis_tvalid <= 1'b0;
    calm = 1'b0;

    // Drain outstanding responses, then allow the pipeline to settle
    while (shadow.expected_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (shadow.errors == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

### filelist.f
hw/rtl/plic_pkg.sv
hw/rtl/platform_interrupt_controller.sv
test/platform_interrupt_controller_tb.sv
